FILE: sv/vcr_pkg.sv
package vcr_pkg;

  // Fixed-point format: signed Q4.12 commands, unsigned 15-bit registers.
  localparam int VALUE_W = 16;
  localparam int CFG_W   = 15;
  localparam int FRAC_W  = 12;

  // Shared divider: one quotient bit per cycle, 16 quotient bits.
  localparam int DIV_STEPS = 16;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // The turn clamp divides (max_turn << 2*FRAC_W) by |curvature| * gain. The
  // quotient is known to fit DIV_STEPS bits, so the low DIV_STEPS zero bits
  // go in as dividend and the rest starts as the partial remainder.
  localparam int CLAMP_SHIFT = 2 * FRAC_W - DIV_STEPS;

  // Register map.
  localparam logic [1:0] REG_MAX_FWD   = 2'd0;
  localparam logic [1:0] REG_MAX_TURN  = 2'd1;
  localparam logic [1:0] REG_TURN_GAIN = 2'd2;
  localparam logic [1:0] REG_SLEW_STEP = 2'd3;

  localparam logic [CFG_W-1:0] RST_MAX_FWD   = 15'd2048;
  localparam logic [CFG_W-1:0] RST_MAX_TURN  = 15'd3195;
  localparam logic [CFG_W-1:0] RST_TURN_GAIN = 15'd4096;
  localparam logic [CFG_W-1:0] RST_SLEW_STEP = 15'd410;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     rem_init;
    logic [DIV_STEPS-1:0] dividend;
    logic [DIV_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_STEPS-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/vcr_div.sv
module vcr_div import vcr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     den;
  logic [DIV_STEPS-1:0] quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh = {rem, quo[DIV_STEPS-1]};
    diff   = rem_sh - {1'b0, den};
    fits   = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      den <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= fits ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_STEPS-2:0], fits};
    end
  end

  assign rsp = '{busy: busy, done: done, quotient: quo};

endmodule

FILE: sv/velocity_command_ramp_top.sv
// Slew-rate limited velocity command generator. Each input beat carries a
// path curvature and a free path length (Q4.12); each one yields exactly one
// output beat with the ramped forward speed and turn rate (signed Q4.12).
// The target speed is min(max_forward_speed, path_length / 3); the target
// turn rate is speed * curvature * turn_gain, clamped to +/- max_turn_rate
// with the speed rescaled to match. Both commands then step from the stored
// last values toward the targets by diff / n, n being the larger of
// floor(|diff| / slew_step) + 1 over the two commands (slew_step 0 acts as 1).
// A stored negative speed clears both stored commands before use.
// Timing: one beat at a time; a new beat is taken only once the last one
// has retired. The length / 3 is one reciprocal multiply, then the shared
// multiplier forms speed * |curvature|, its product with the gain and the
// clamp divisor; then come the clamp check and the differences, and four
// (five with the clamp) 16-step divisions on the one shared restoring
// divider, each with its start and finish hand-off, then a retire step and
// an idle step. The result sits in an output register, so the next beat is
// taken while it waits; a result still waiting at the retire step holds the
// block there.
// Configuration writes are taken at any edge with cfg_write_en high and
// must only happen while the block is idle.
module velocity_command_ramp_top import vcr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] curvature,
  input  logic [CFG_W-1:0]          path_length,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] forward_speed,
  output logic signed [VALUE_W-1:0] turn_rate
);

  // Sequencer codes.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LEN   = 4'd1;
  localparam logic [3:0] ST_MUL1  = 4'd2;
  localparam logic [3:0] ST_MUL2  = 4'd3;
  localparam logic [3:0] ST_MUL3  = 4'd4;
  localparam logic [3:0] ST_CHECK = 4'd5;
  localparam logic [3:0] ST_CLAMP = 4'd6;
  localparam logic [3:0] ST_DIFF  = 4'd7;
  localparam logic [3:0] ST_NV    = 4'd8;
  localparam logic [3:0] ST_NR    = 4'd9;
  localparam logic [3:0] ST_QV    = 4'd10;
  localparam logic [3:0] ST_QR    = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  // Shared multiplier: speed * |curvature| and |curvature| * gain both stay
  // below 2^30; their product with the gain stays below 2^46.
  localparam int MUL_A_W = 2 * CFG_W;
  localparam int MUL_B_W = VALUE_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int MAG_W   = PROD_W - 2 * FRAC_W;
  // length / 3 as (length * ceil(2^17 / 3)) >> 17, exact for any length
  // below 2^17.
  localparam int                 RECIP_SHIFT = 17;
  localparam logic [MUL_B_W-1:0] RECIP_THREE = 16'd43691;

  // Configuration registers.
  logic [CFG_W-1:0] max_fwd;
  logic [CFG_W-1:0] max_turn;
  logic [CFG_W-1:0] turn_gain;
  logic [CFG_W-1:0] slew_step;

  // Stored commands.
  logic signed [VALUE_W-1:0] last_speed;
  logic signed [VALUE_W-1:0] last_turn;

  logic [3:0] state;
  logic       go;

  // Per-item working registers.
  logic                      curv_neg;
  logic [VALUE_W-1:0]        acurv;
  logic [CFG_W-1:0]          len;
  logic                      over;
  logic [CFG_W-1:0]          vx;
  logic [MUL_A_W-1:0]        p1;
  logic [MUL_A_W-1:0]        den;
  logic [MAG_W-1:0]          mag;
  logic signed [VALUE_W:0]   dv;
  logic signed [VALUE_W:0]   dr;
  logic [VALUE_W:0]          nv;
  logic [VALUE_W:0]          nr;
  logic [VALUE_W-1:0]        qv;
  logic [VALUE_W-1:0]        qr;

  logic                      in_fire;
  logic                      done_fire;
  logic                      clamp_hit;
  logic                      go_next;
  logic [CFG_W+1:0]          fwd_x3;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [PROD_W-1:0]         prod;
  logic signed [VALUE_W:0]   rz;
  logic [VALUE_W-1:0]        adv;
  logic [VALUE_W-1:0]        adr;
  logic [VALUE_W:0]          n_max;
  logic [CFG_W-1:0]          step_eff;
  logic signed [VALUE_W:0]   inc_v;
  logic signed [VALUE_W:0]   inc_r;
  logic signed [VALUE_W:0]   sum_v;
  logic signed [VALUE_W:0]   sum_r;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  // Retire only when the output register is free or drains this cycle.
  assign done_fire = (state == ST_DONE) && (!out_valid || out_ready);
  assign clamp_hit = (mag > MAG_W'(max_turn));

  // Launch a divide on the first cycle of each dividing step.
  assign go_next = ((state == ST_CHECK) && clamp_hit) || (state == ST_DIFF) ||
                   (div_rsp.done &&
                    ((state == ST_NV) || (state == ST_NR) || (state == ST_QV)));

  assign fwd_x3 = {2'b00, max_fwd} + {1'b0, max_fwd, 1'b0};

  // Shared multiplier operand select.
  always_comb begin
    unique case (state)
      ST_LEN: begin
        mul_a = MUL_A_W'(len);
        mul_b = RECIP_THREE;
      end
      ST_MUL1: begin
        mul_a = MUL_A_W'(vx);
        mul_b = acurv;
      end
      ST_MUL2: begin
        mul_a = p1;
        mul_b = MUL_B_W'(turn_gain);
      end
      default: begin
        mul_a = MUL_A_W'(acurv);
        mul_b = MUL_B_W'(turn_gain);
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Target turn rate: mag is already limited to max_turn here.
  assign rz = curv_neg ? -$signed({2'b00, mag[CFG_W-1:0]})
                       :  $signed({2'b00, mag[CFG_W-1:0]});

  assign adv      = dv[VALUE_W] ? VALUE_W'(-dv) : dv[VALUE_W-1:0];
  assign adr      = dr[VALUE_W] ? VALUE_W'(-dr) : dr[VALUE_W-1:0];
  assign n_max    = (nv > nr) ? nv : nr;
  assign step_eff = (slew_step == '0) ? CFG_W'(1) : slew_step;

  // Ramp increments keep the sign of the difference (truncation toward zero).
  assign inc_v = dv[VALUE_W] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
  assign inc_r = dr[VALUE_W] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
  assign sum_v = {last_speed[VALUE_W-1], last_speed} + inc_v;
  assign sum_r = {last_turn[VALUE_W-1], last_turn} + inc_r;

  // Divider operand select; start pulses on the first cycle of each divide.
  always_comb begin
    div_req       = '0;
    div_req.start = go;
    unique case (state)
      ST_CLAMP: begin
        div_req.rem_init = DIV_W'({max_turn, {CLAMP_SHIFT{1'b0}}});
        div_req.divisor  = DIV_W'(den);
      end
      ST_NV: begin
        div_req.dividend = adv;
        div_req.divisor  = DIV_W'(step_eff);
      end
      ST_NR: begin
        div_req.dividend = adr;
        div_req.divisor  = DIV_W'(step_eff);
      end
      ST_QV: begin
        div_req.dividend = adv;
        div_req.divisor  = DIV_W'(n_max);
      end
      ST_QR: begin
        div_req.dividend = adr;
        div_req.divisor  = DIV_W'(n_max);
      end
      default: begin
        div_req.dividend = '0;
      end
    endcase
  end

  vcr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Control: sequencer, stored commands, configuration, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      go         <= 1'b0;
      out_valid  <= 1'b0;
      last_speed <= '0;
      last_turn  <= '0;
      max_fwd    <= RST_MAX_FWD;
      max_turn   <= RST_MAX_TURN;
      turn_gain  <= RST_TURN_GAIN;
      slew_step  <= RST_SLEW_STEP;
    end else begin
      go        <= go_next;
      // Hold the result until taken; a retiring item refills the register.
      out_valid <= done_fire || (out_valid && !out_ready);
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_MAX_FWD:   max_fwd   <= cfg_data;
          REG_MAX_TURN:  max_turn  <= cfg_data;
          REG_TURN_GAIN: turn_gain <= cfg_data;
          REG_SLEW_STEP: slew_step <= cfg_data;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            // Drop a negative stored speed together with the stored turn.
            if (last_speed[VALUE_W-1]) begin
              last_speed <= '0;
              last_turn  <= '0;
            end
            state <= ST_LEN;
          end
        end
        ST_LEN:  state <= ST_MUL1;
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_MUL3;
        ST_MUL3: state <= ST_CHECK;
        ST_CHECK: begin
          if (clamp_hit) begin
            state <= ST_CLAMP;
          end else begin
            state <= ST_DIFF;
          end
        end
        ST_CLAMP: begin
          if (div_rsp.done) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF: state <= ST_NV;
        ST_NV: begin
          if (div_rsp.done) begin
            state <= ST_NR;
          end
        end
        ST_NR: begin
          if (div_rsp.done) begin
            state <= ST_QV;
          end
        end
        ST_QV: begin
          if (div_rsp.done) begin
            state <= ST_QR;
          end
        end
        ST_QR: begin
          if (div_rsp.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_fire) begin
            // Each step lands between the stored value and the target, so
            // the result always fits the command range.
            last_speed <= sum_v[VALUE_W-1:0];
            last_turn  <= sum_r[VALUE_W-1:0];
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      curv_neg <= curvature[VALUE_W-1];
      acurv    <= curvature[VALUE_W-1] ? VALUE_W'(-curvature) : curvature;
      len      <= path_length;
      over     <= ({2'b00, path_length} > fwd_x3);
    end
    if (state == ST_LEN) begin
      vx <= over ? max_fwd : prod[RECIP_SHIFT +: CFG_W];
    end
    if (state == ST_MUL1) begin
      p1 <= prod[MUL_A_W-1:0];
    end
    if (state == ST_MUL2) begin
      mag <= prod[PROD_W-1:2*FRAC_W];
    end
    if (state == ST_MUL3) begin
      den <= prod[MUL_A_W-1:0];
    end
    if ((state == ST_CLAMP) && div_rsp.done) begin
      vx  <= div_rsp.quotient[CFG_W-1:0];
      mag <= MAG_W'(max_turn);
    end
    if (state == ST_DIFF) begin
      dv <= $signed({2'b00, vx}) - {last_speed[VALUE_W-1], last_speed};
      dr <= rz - {last_turn[VALUE_W-1], last_turn};
    end
    if ((state == ST_NV) && div_rsp.done) begin
      nv <= {1'b0, div_rsp.quotient} + 1'b1;
    end
    if ((state == ST_NR) && div_rsp.done) begin
      nr <= {1'b0, div_rsp.quotient} + 1'b1;
    end
    if ((state == ST_QV) && div_rsp.done) begin
      qv <= div_rsp.quotient;
    end
    if ((state == ST_QR) && div_rsp.done) begin
      qr <= div_rsp.quotient;
    end
    if (done_fire) begin
      forward_speed <= sum_v[VALUE_W-1:0];
      turn_rate     <= sum_r[VALUE_W-1:0];
    end
  end

  // The stored speed only ever ramps between non-negative values.
  a_speed_nonneg: assert property (@(posedge clk) disable iff (rst)
    !last_speed[VALUE_W-1])
    else $error("stored forward speed went negative");

  // A divide is only launched on an idle divider.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // A new result beat comes only from the final sequencer step.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("output valid rose outside the final step");

  // The turn command never reaches the most negative code.
  a_turn_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> turn_rate != {1'b1, {(VALUE_W-1){1'b0}}})
    else $error("turn rate out of clamped range");

endmodule

FILE: tb/velocity_command_ramp_top_test.sv
`timescale 1ns / 100ps

module velocity_command_ramp_top_test;
  import vcr_pkg::*;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT  = 3000;
  // Cycles to hold after the last result when draining, as before a register write.
  localparam int DRAIN_TAIL   = 8;
  // Cycles to hold after the last result before the verdict.
  localparam int END_TAIL     = 150;
  localparam int PHASE_COUNT  = 7;
  localparam int PHASE_ITEMS  = 72;

  // One commanded velocity pair, as it leaves the block.
  typedef struct packed {
    logic signed [VALUE_W-1:0] speed;
    logic signed [VALUE_W-1:0] turn;
  } cmd_t;

  // One row of the directed table. Where typed is set, the expected command
  // is the one given in the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic signed [VALUE_W-1:0] curv;
    logic [CFG_W-1:0]          len;
    logic                      typed;
    logic signed [VALUE_W-1:0] speed;
    logic signed [VALUE_W-1:0] turn;
  } ramp_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write_en = 1'b0;
  logic [1:0]                cfg_index = REG_MAX_FWD;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] curvature = '0;
  logic [CFG_W-1:0]          path_length = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] forward_speed;
  logic signed [VALUE_W-1:0] turn_rate;

  // Typed expectation travelling alongside the beat on the input channel.
  logic                      beat_typed = 1'b0;
  logic signed [VALUE_W-1:0] beat_speed = '0;
  logic signed [VALUE_W-1:0] beat_turn = '0;

  // Register shadow and held commands of the predictor.
  logic [CFG_W-1:0]          lim_fwd   = RST_MAX_FWD;
  logic [CFG_W-1:0]          lim_turn  = RST_MAX_TURN;
  logic [CFG_W-1:0]          gain_turn = RST_TURN_GAIN;
  logic [CFG_W-1:0]          slew_q    = RST_SLEW_STEP;
  logic signed [VALUE_W-1:0] held_speed = '0;
  logic signed [VALUE_W-1:0] held_turn = '0;

  cmd_t pending_cmds[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  // Directed rows, all under the reset settings. A zero path length from a
  // zero held state gives a zero command whatever the curvature.
  ramp_row_t ramp_rows [15] = '{
    '{16'sd0,      15'd0,     1'b1, 16'sd0, 16'sd0},
    '{16'sh7FFF,   15'd0,     1'b1, 16'sd0, 16'sd0},
    '{16'sh8000,   15'd0,     1'b1, 16'sd0, 16'sd0},
    // ramp up straight ahead at the speed limit, several beats in a row
    '{16'sd0,      15'h7FFF,  1'b0, 16'sd0, 16'sd0},
    '{16'sd0,      15'h7FFF,  1'b0, 16'sd0, 16'sd0},
    '{16'sd0,      15'h7FFF,  1'b0, 16'sd0, 16'sd0},
    // sharpest curves both ways: turn clamp with speed rescale; then gentlest ones
    '{16'sh7FFF,   15'h7FFF,  1'b0, 16'sd0, 16'sd0},
    '{16'sh8000,   15'h7FFF,  1'b0, 16'sd0, 16'sd0},
    '{16'shFFFF,   15'h7FFF,  1'b0, 16'sd0, 16'sd0},
    '{16'sd1,      15'd3,     1'b0, 16'sd0, 16'sd0},
    // path length around three times the speed limit, then a longer negative curve
    '{16'sd100,    15'd6143,  1'b0, 16'sd0, 16'sd0},
    '{16'sd100,    15'd6144,  1'b0, 16'sd0, 16'sd0},
    '{16'sd100,    15'd6145,  1'b0, 16'sd0, 16'sd0},
    '{-16'sd4096,  15'd12000, 1'b0, 16'sd0, 16'sd0},
    // ramp back down toward a standstill
    '{16'sd0,      15'd0,     1'b0, 16'sd0, 16'sd0}
  };

  velocity_command_ramp_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .curvature    (curvature),
    .path_length  (path_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .forward_speed(forward_speed),
    .turn_rate    (turn_rate)
  );

  always #5 clk = ~clk;

  // Clip to the signed command range.
  function automatic longint clip_cmd(input longint v);
    longint hi;
    hi = (longint'(1) <<< (VALUE_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Work out the next ramped command for one path beat and advance the held
  // commands, exactly as the block does.
  function automatic cmd_t ramp_command(input logic signed [VALUE_W-1:0] curv,
                                        input logic [CFG_W-1:0] len);
    longint from_v, from_r, tgt_v, tgt_r, acurv, mag, den, path, fwd_max;
    longint turn_max, gain, quantum, diff_v, diff_r, steps_v, steps_r, steps;
    cmd_t nxt;
    from_v   = held_speed;
    from_r   = held_turn;
    path     = len;
    fwd_max  = lim_fwd;
    turn_max = lim_turn;
    gain     = gain_turn;
    // A negative held speed drops both held commands first.
    if (from_v < 0) begin
      from_v = 0;
      from_r = 0;
    end
    if (path > fwd_max * 3) tgt_v = fwd_max;
    else tgt_v = path / 3;
    acurv = curv;
    if (acurv < 0) acurv = -acurv;
    mag = (tgt_v * acurv * gain) >> (2 * FRAC_W);
    // Too fast a turn: hold the turn at the limit, slow down to match.
    if (mag > turn_max) begin
      den   = acurv * gain;
      tgt_v = (turn_max << (2 * FRAC_W)) / den;
      mag   = turn_max;
    end
    tgt_r = (curv < 0) ? -mag : mag;
    tgt_v = clip_cmd(tgt_v);
    tgt_r = clip_cmd(tgt_r);
    diff_v  = tgt_v - from_v;
    diff_r  = tgt_r - from_r;
    quantum = (slew_q == '0) ? 1 : longint'(slew_q);
    steps_v = ((diff_v < 0) ? -diff_v : diff_v) / quantum + 1;
    steps_r = ((diff_r < 0) ? -diff_r : diff_r) / quantum + 1;
    steps   = (steps_v > steps_r) ? steps_v : steps_r;
    nxt.speed  = clip_cmd(from_v + diff_v / steps);
    nxt.turn   = clip_cmd(from_r + diff_r / steps);
    held_speed = nxt.speed;
    held_turn  = nxt.turn;
    return nxt;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Receiver: drop ready at the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Scoreboard: check the result beat against the oldest expectation, then
  // predict for a path beat taken at the same edge. Guard against a hang.
  always @(posedge clk) begin : scoreboard
    cmd_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (pending_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected command %0d/%0d",
                                    forward_speed, turn_rate));
        end else begin
          want = pending_cmds.pop_front();
          if (forward_speed !== want.speed)
            report_mismatch($sformatf("forward_speed %0d, expected %0d (result %0d)",
                                      forward_speed, want.speed, beats_out));
          if (turn_rate !== want.turn)
            report_mismatch($sformatf("turn_rate %0d, expected %0d (result %0d)",
                                      turn_rate, want.turn, beats_out));
        end
      end
      if (in_valid && in_ready) begin
        beats_in++;
        want = ramp_command(curvature, path_length);
        if (beat_typed) begin
          want.speed = beat_speed;
          want.turn  = beat_turn;
        end
        pending_cmds = {pending_cmds, want};
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one path beat, idling first at the sender rate; hold it until taken.
  task automatic send_path(input logic signed [VALUE_W-1:0] curv,
                           input logic [CFG_W-1:0] len, input logic typed,
                           input logic signed [VALUE_W-1:0] t_speed,
                           input logic signed [VALUE_W-1:0] t_turn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    curvature   <= curv;
    path_length <= len;
    beat_typed  <= typed;
    beat_speed  <= t_speed;
    beat_turn   <= t_turn;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Hold off the sender until every command sent has come back.
  task automatic drain_commands();
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_out != items_sent);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Write all four registers on back-to-back edges, block idle.
  task automatic load_settings(input logic [CFG_W-1:0] fwd, input logic [CFG_W-1:0] turn,
                               input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] slew);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_MAX_FWD;
    cfg_data     <= fwd;
    @(posedge clk);
    cfg_index    <= REG_MAX_TURN;
    cfg_data     <= turn;
    @(posedge clk);
    cfg_index    <= REG_TURN_GAIN;
    cfg_data     <= gain;
    @(posedge clk);
    cfg_index    <= REG_SLEW_STEP;
    cfg_data     <= slew;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    lim_fwd   = fwd;
    lim_turn  = turn;
    gain_turn = gain;
    slew_q    = slew;
  endtask

  // Curvature mix: full range, gentle curves, moderate curves, extremes.
  function automatic logic signed [VALUE_W-1:0] pick_curvature();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(128) - 64;
      1: v = $urandom_range(16384) - 8192;
      2: begin
        case ($urandom_range(4))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          3: v = 1;
          default: v = 0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v[VALUE_W-1:0];
  endfunction

  // Path length mix: full range, short paths, the speed-limit knee, and the two extremes.
  function automatic logic [CFG_W-1:0] pick_length();
    int knee;
    knee = 3 * int'(lim_fwd) + $urandom_range(2) - 1;
    if (knee > 32767) knee = 32767;
    if (knee < 0) knee = 0;
    case ($urandom_range(4))
      0: return CFG_W'($urandom_range(64));
      1: return CFG_W'(knee);
      2: return ($urandom_range(1) != 0) ? '1 : '0;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic signed [VALUE_W-1:0] curv;
    logic [CFG_W-1:0]          len;
    curv = '0;
    len  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset settings; sender sparse, receiver slow.
    send_idle_pct = 7;
    recv_idle_pct = 67;
    foreach (ramp_rows[r])
      send_path(ramp_rows[r].curv, ramp_rows[r].len, ramp_rows[r].typed,
                ramp_rows[r].speed, ramp_rows[r].turn);
    drain_commands();

    // Random phases, each under its own register settings. Swap the idling
    // sides after three phases, then run the last two flat out.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 7;
      end else if (phase == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        1: load_settings('1, '1, '1, '1);
        2: load_settings('0, '0, 15'd1, 15'd1);
        // zero gain disables turning; zero slew quantum acts as one
        3: load_settings('1, '0, '0, '0);
        4: load_settings(15'd12000, 15'd800, 15'd8192, 15'd64);
        5, 6: load_settings(CFG_W'($urandom), CFG_W'($urandom),
                            CFG_W'($urandom_range(32767, 1)),
                            CFG_W'($urandom_range(4096, 1)));
        default: ;
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Repeat the last path now and then so the ramp gets to converge.
        if (k == 0 || $urandom_range(3) != 0) begin
          curv = pick_curvature();
          len  = pick_length();
        end
        send_path(curv, len, 1'b0, '0, '0);
        if ($urandom_range(59) == 0) drain_commands();
      end
      drain_commands();
    end

    // Wind down: every command back, then a quiet tail.
    in_valid <= 1'b0;
    while (beats_out != items_sent) @(posedge clk);
    repeat (END_TAIL) @(posedge clk);
    if (pending_cmds.size() != 0)
      report_mismatch($sformatf("%0d commands never came out", pending_cmds.size()));
    $display("Ran %0d path beats in and %0d commands out over %0d register settings,",
             beats_in, beats_out, PHASE_COUNT);
    $display("with idling on either side and flat out; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
